@@ hw/rtl/nlms_pkg.sv @@
// ----------------------------------------------------------------------------
// NLMS echo canceller package
// Shared widths, register indexes and the per-item status passed between the
// top level and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package nlms_pkg;

    localparam int TAP_COUNT = 128;
    localparam int TAP_W     = $clog2(TAP_COUNT);

    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_FLOOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_POLE = 2'd3;

    localparam logic [14:0] STEP_SIZE_RST     = 15'd8192;
    localparam logic [31:0] POWER_FLOOR_RST   = 32'd8000;
    localparam logic [17:0] WEIGHT_LIMIT_RST  = 18'd131072;
    localparam logic [14:0] HIGHPASS_POLE_RST = 15'd32440;

    // Power sum: TAP_COUNT * 2^30 plus one.
    localparam int POWER_W = 31 + TAP_W + 1;
    // Numerator e*r*mu: 16+16+15 bits signed.
    localparam int NUM_W   = 48;
    localparam int ACC_W   = 35 + TAP_W + 1;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W:0] v);
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        hi = (ACC_W+1)'(32767);
        lo = -(ACC_W+1)'(32768);
        if (v > hi)
            return 16'sh7fff;
        else if (v < lo)
            return 16'sh8000;
        else
            return v[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nlms_if.sv @@
// ----------------------------------------------------------------------------
// NLMS stream interfaces
// Valid/ready channels for input sample pairs and cleaned output samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlms_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] mic_sample;
    logic signed [15:0] far_sample;
    modport source (output valid, output mic_sample, output far_sample, input ready);
    modport sink (input valid, input mic_sample, input far_sample, output ready);
endinterface

interface nlms_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] clean_sample;
    modport source (output valid, output clean_sample, input ready);
    modport sink (input valid, input clean_sample, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/nlms_div.sv @@
// ----------------------------------------------------------------------------
// NLMS signed divider
// Restoring divider, one quotient bit per cycle, quotient truncated toward
// zero. Used once per tap to form the weight update.
// ----------------------------------------------------------------------------
`default_nettype none

module nlms_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [nlms_pkg::NUM_W-1:0]   numer,
    input  wire logic [nlms_pkg::POWER_W-1:0]        denom,
    output nlms_pkg::div_ctl_t                 ctl,
    output logic signed [nlms_pkg::NUM_W-1:0]  quot
);
    import nlms_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   q_reg;
    logic [POWER_W:0]   rem_reg;
    logic [POWER_W-1:0] d_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [POWER_W:0]   trial;
    logic [POWER_W:0]   diff;

    assign trial = {rem_reg[POWER_W-1:0], q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= numer[NUM_W-1];
            q_reg   <= numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
            rem_reg <= '0;
            d_reg   <= denom;
        end
        else if (busy_reg)
        begin
            if (!diff[POWER_W])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quot      = neg_reg ? -$signed(q_reg) : $signed(q_reg);

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

endmodule

`default_nettype wire

@@ hw/rtl/nlms_echo_canceller_core.sv @@
// ----------------------------------------------------------------------------
// NLMS echo canceller core
// DC-blocks microphone and far-end samples, estimates the echo with a
// 128-tap adaptive FIR and returns the cleaned microphone sample.
// ----------------------------------------------------------------------------
// Usage: in_ch takes one mic/far sample pair per item; out_ch returns one
// clean sample per item. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while the block is idle, and the
// block itself does not enforce this. Indexes beyond the register list are ignored.
// History and weights live in two synchronous memories. The forward pass
// reads one tap per cycle. If the window power exceeds the floor, the
// update pass reads a tap, forms the numerator, runs the serial divider
// and writes the clamped weight back, tap by tap. On an adapting item the
// divider sets the rate. Reset clears both memories in a clearing pass over
// every tap, during which in_ch.ready stays low. The result sits in an
// output register; the next item is accepted only once it has been taken,
// so a stalled receiver holds the block.
// ----------------------------------------------------------------------------
`default_nettype none

module nlms_echo_canceller_core (
    input  wire logic clk,
    input  wire logic rst_n,
    nlms_in_if.sink   in_ch,
    nlms_out_if.source out_ch,
    input  wire logic cfg_we,
    input  wire logic [nlms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nlms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nlms_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HPF   = 3'd2;
    localparam logic [2:0] S_FIR   = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Update sub-steps.
    localparam logic [1:0] U_READ = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_WAIT = 2'd3;

    logic [14:0] step_size_reg;
    logic [31:0] power_floor_reg;
    logic [17:0] weight_limit_reg;
    logic [14:0] highpass_pole_reg;

    logic [2:0]  state_reg;
    logic [1:0]  usub_reg;
    logic [TAP_W:0] cnt_reg;
    logic [TAP_W-1:0] wpos_reg;
    logic        out_valid_reg;
    logic        rd_valid_reg;

    logic signed [15:0] mic_prev_in_reg, far_prev_in_reg;
    logic signed [31:0] mic_prev_out_reg, far_prev_out_reg;
    logic signed [15:0] mic_hp_reg;
    logic signed [15:0] mic_in_reg, far_in_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [POWER_W-1:0] pwr_reg;
    logic signed [15:0] e_reg;
    logic signed [31:0] er_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic signed [15:0] clean_reg;

    // Memories.
    logic signed [15:0] hist_mem [TAP_COUNT];
    logic signed [WEIGHT_W-1:0] wt_mem [TAP_COUNT];
    logic signed [15:0] hist_q;
    logic signed [WEIGHT_W-1:0] wt_q;
    logic [TAP_W-1:0] tap_idx;
    logic [TAP_W-1:0] hist_addr;
    logic [TAP_W-1:0] wt_waddr;
    logic        hist_we;
    logic signed [15:0] hist_wd;
    logic        wt_we;
    logic signed [WEIGHT_W-1:0] wt_wd;
    logic [TAP_W-1:0] tap_q_reg;

    // Divider.
    logic div_start;
    div_ctl_t div_ctl;
    logic signed [NUM_W-1:0] div_q;

    // High-pass products.
    logic signed [48:0] mic_fb, far_fb;
    logic signed [ACC_W:0] mic_y, far_y;
    logic signed [ACC_W:0] err_full;
    logic signed [WEIGHT_W+NUM_W:0] nw;
    logic signed [WEIGHT_W+NUM_W:0] lim_ext;

    // Forward pass products.
    logic signed [34:0] tap_prod;
    logic [31:0] hist_sq;

    logic in_fire;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.clean_sample = clean_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg     <= STEP_SIZE_RST;
            power_floor_reg   <= POWER_FLOOR_RST;
            weight_limit_reg  <= WEIGHT_LIMIT_RST;
            highpass_pole_reg <= HIGHPASS_POLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_SIZE:     step_size_reg     <= cfg_data[14:0];
                REG_POWER_FLOOR:   power_floor_reg   <= cfg_data;
                REG_WEIGHT_LIMIT:  weight_limit_reg  <= cfg_data[17:0];
                REG_HIGHPASS_POLE: highpass_pole_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // The floor of a product by a shift is an arithmetic right shift.
    assign mic_fb = (mic_prev_out_reg * $signed({1'b0, highpass_pole_reg})) >>> 15;
    assign far_fb = (far_prev_out_reg * $signed({1'b0, highpass_pole_reg})) >>> 15;
    assign mic_y  = (ACC_W+1)'(mic_in_reg) - (ACC_W+1)'(mic_prev_in_reg) + (ACC_W+1)'(mic_fb);
    assign far_y  = (ACC_W+1)'(far_in_reg) - (ACC_W+1)'(far_prev_in_reg) + (ACC_W+1)'(far_fb);
    assign err_full = (ACC_W+1)'(mic_hp_reg) - (ACC_W+1)'(acc_reg >>> 15);

    assign tap_prod = wt_q * hist_q;
    assign hist_sq  = hist_q * hist_q;

    // Tap i reads history at write_pos - i.
    assign tap_idx   = cnt_reg[TAP_W-1:0];
    assign hist_addr = (state_reg == S_CLEAR) ? tap_idx :
                       (state_reg == S_HPF) ? wpos_reg : wpos_reg - tap_idx;

    assign hist_we = (state_reg == S_CLEAR) || (state_reg == S_HPF);
    assign hist_wd = (state_reg == S_CLEAR) ? 16'sd0 : sat16(far_y);
    assign wt_waddr = (state_reg == S_CLEAR) ? tap_idx : tap_q_reg;

    assign lim_ext = (WEIGHT_W+NUM_W+1)'({1'b0, weight_limit_reg});
    assign nw = (WEIGHT_W+NUM_W+1)'(wt_q) + (WEIGHT_W+NUM_W+1)'(div_q);

    always_comb
    begin
        wt_we = 1'b0;
        wt_wd = '0;
        if (state_reg == S_CLEAR)
            wt_we = 1'b1;
        else if (state_reg == S_UPD && usub_reg == U_WAIT && div_ctl.done)
        begin
            wt_we = 1'b1;
            if (nw > lim_ext)
                wt_wd = WEIGHT_W'(lim_ext);
            else if (nw < -lim_ext)
                wt_wd = WEIGHT_W'(-lim_ext);
            else
                wt_wd = WEIGHT_W'(nw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_addr] <= hist_wd;
        hist_q <= hist_mem[hist_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
            wt_mem[wt_waddr] <= wt_wd;
        wt_q <= wt_mem[tap_idx];
    end

    assign div_start = (state_reg == S_UPD) && (usub_reg == U_DIV);

    nlms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (num_reg),
        .denom (pwr_reg),
        .ctl   (div_ctl),
        .quot  (div_q)
    );

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            usub_reg      <= U_READ;
            cnt_reg       <= '0;
            wpos_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            mic_prev_in_reg  <= '0;
            far_prev_in_reg  <= '0;
            mic_prev_out_reg <= '0;
            far_prev_out_reg <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (TAP_W+1)'(TAP_COUNT - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                        state_reg <= S_HPF;
                end
                S_HPF:
                begin
                    mic_prev_in_reg  <= mic_in_reg;
                    far_prev_in_reg  <= far_in_reg;
                    mic_prev_out_reg <= mic_y[31:0];
                    far_prev_out_reg <= far_y[31:0];
                    cnt_reg      <= '0;
                    rd_valid_reg <= 1'b0;
                    state_reg    <= S_FIR;
                end
                S_FIR:
                begin
                    // Issue one read per cycle; accumulate its data in the next cycle.
                    rd_valid_reg <= !cnt_reg[TAP_W];
                    if (!cnt_reg[TAP_W])
                        cnt_reg <= cnt_reg + 1'b1;
                    else if (!rd_valid_reg)
                        state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    cnt_reg  <= '0;
                    usub_reg <= U_READ;
                    if (pwr_reg > POWER_W'(power_floor_reg))
                        state_reg <= S_UPD;
                    else
                    begin
                        wpos_reg  <= wpos_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_UPD:
                begin
                    case (usub_reg)
                        U_READ: usub_reg <= U_MUL;
                        U_MUL:  usub_reg <= U_DIV;
                        U_DIV:  usub_reg <= U_WAIT;
                        U_WAIT:
                        begin
                            if (div_ctl.done)
                            begin
                                usub_reg <= U_READ;
                                cnt_reg  <= cnt_reg + 1'b1;
                                if (cnt_reg == (TAP_W+1)'(TAP_COUNT - 1))
                                begin
                                    wpos_reg  <= wpos_reg + 1'b1;
                                    state_reg <= S_OUT;
                                end
                            end
                        end
                        default: usub_reg <= U_READ;
                    endcase
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mic_in_reg <= in_ch.mic_sample;
            far_in_reg <= in_ch.far_sample;
        end
        if (state_reg == S_HPF)
        begin
            mic_hp_reg <= sat16(mic_y);
            acc_reg    <= '0;
            pwr_reg    <= POWER_W'(1);
        end
        if (state_reg == S_FIR)
        begin
            tap_q_reg <= tap_idx;
            if (rd_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(tap_prod);
                pwr_reg <= pwr_reg + POWER_W'(hist_sq);
            end
        end
        if (state_reg == S_ERR)
            e_reg <= sat16(err_full);
        if (state_reg == S_UPD)
        begin
            // The numerator is ready by the cycle that starts the divider.
            if (usub_reg == U_READ)
            begin
                tap_q_reg <= tap_idx;
                er_reg    <= e_reg * $signed({1'b0, step_size_reg});
            end
            if (usub_reg == U_MUL)
                num_reg <= NUM_W'(er_reg) * NUM_W'(hist_q);
        end
        if (state_reg == S_OUT)
            clean_reg <= e_reg;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == S_IDLE)
        else $error("item accepted while busy");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> out_valid_reg)
        else $error("result not posted");
    a_div_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.busy |-> state_reg == S_UPD)
        else $error("divider busy outside update");

endmodule

`default_nettype wire
